/* design/assert_macros.svh */
// assertion macros used by the shader top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, suspended while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// clocked check that also runs during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* design/clps_pkg.sv */
// types and constants of the circle list pixel shader
`timescale 1ns / 1ps

package clps_pkg;

    // input operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SHADE = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_INV_HEIGHT    = 2'd2;
    localparam logic [1:0] REG_CIRCLE_COUNT  = 2'd3;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 25;

    // register reset values
    localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd1024;
    localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd768;
    localparam logic [24:0] RST_INV_HEIGHT    = 25'd21845;
    localparam logic [8:0]  RST_CIRCLE_COUNT  = 9'd0;

    // fraction bits of the reciprocal
    localparam int INV_FRAC = 24;

    // color of an uncovered pixel
    localparam logic [31:0] BLACK_OPAQUE = 32'hFF000000;

    // one circle table entry
    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [14:0] radius;
        logic [31:0] color;
    } entry_t;

    // status of the coverage pipeline
    typedef struct packed {
        logic busy;
        logic hit;
    } hit_status_t;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROUND,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

/* design/clps_table.sv */
// circle table memory with one write port and one registered read port
`timescale 1ns / 1ps

module clps_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  clps_pkg::entry_t  wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output clps_pkg::entry_t  rd_data
);
    import clps_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/clps_coord.sv */
// maps a pixel coordinate to a signed world coordinate
`timescale 1ns / 1ps

module clps_coord #(
    parameter int FRAC = 12
) (
    input  logic               aclk,
    input  logic               load,
    input  logic [11:0]        pix,
    input  logic [12:0]        extent,
    input  logic [24:0]        inv,
    output logic signed [15:0] coord
);
    import clps_pkg::*;

    localparam int SH = INV_FRAC - FRAC;

    logic signed [13:0] d;
    logic        [12:0] d_abs;
    logic        [37:0] mag_reg;
    logic               neg_reg;
    logic        [37:0] q;
    logic        [37:0] q_inc;
    logic               frac_nz;

    // offset from screen center, twice the pixel minus the extent
    assign d     = $signed({1'b0, pix, 1'b0}) - $signed({1'b0, extent});
    assign d_abs = d[13] ? 13'(-d) : 13'(d);

    // magnitude times reciprocal, registered
    always_ff @(posedge aclk) begin
        if (load) begin
            mag_reg <= 38'(d_abs) * 38'(inv);
            neg_reg <= d[13];
        end
    end

    // floor to the coordinate grid and saturate
    assign q       = mag_reg >> SH;
    assign frac_nz = |(mag_reg & ((38'd1 << SH) - 38'd1));
    assign q_inc   = q + 38'(frac_nz);

    always_comb begin
        if (neg_reg) begin
            if (q_inc > 38'd32768) begin
                coord = 16'sh8000;
            end else begin
                coord = $signed(16'(16'd0 - q_inc[15:0]));
            end
        end else begin
            if (q > 38'd32767) begin
                coord = 16'sh7FFF;
            end else begin
                coord = $signed(q[15:0]);
            end
        end
    end

endmodule

/* design/clps_hit.sv */
// coverage test pipeline: distance, squares, compare
`timescale 1ns / 1ps

module clps_hit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   flush,
    input  logic                   in_vld,
    input  clps_pkg::entry_t       entry,
    input  logic signed [15:0]     u,
    input  logic signed [15:0]     v,
    output clps_pkg::hit_status_t  status,
    output logic [31:0]            color
);
    import clps_pkg::*;

    logic               s1_vld_reg;
    logic               s2_vld_reg;
    logic signed [16:0] dx_reg;
    logic signed [16:0] dy_reg;
    logic        [14:0] r1_reg;
    logic        [31:0] col1_reg;
    logic signed [33:0] dx_sq;
    logic signed [33:0] dy_sq;
    logic        [29:0] r_sq;
    logic        [32:0] dx2_reg;
    logic        [32:0] dy2_reg;
    logic        [29:0] r2_reg;
    logic        [31:0] col2_reg;
    logic        [33:0] dist2;
    logic               less;

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else if (flush) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // stage one: differences to the pixel
    always_ff @(posedge aclk) begin
        dx_reg   <= $signed({entry.cx[15], entry.cx}) - $signed({u[15], u});
        dy_reg   <= $signed({entry.cy[15], entry.cy}) - $signed({v[15], v});
        r1_reg   <= entry.radius;
        col1_reg <= entry.color;
    end

    // stage two: squares
    assign dx_sq = 34'(dx_reg) * 34'(dx_reg);
    assign dy_sq = 34'(dy_reg) * 34'(dy_reg);
    assign r_sq  = 30'(r1_reg) * 30'(r1_reg);

    always_ff @(posedge aclk) begin
        dx2_reg  <= dx_sq[32:0];
        dy2_reg  <= dy_sq[32:0];
        r2_reg   <= r_sq;
        col2_reg <= col1_reg;
    end

    // strict inside test
    assign dist2 = 34'(dx2_reg) + 34'(dy2_reg);
    assign less  = dist2 < 34'(r2_reg);

    assign status.busy = s1_vld_reg | s2_vld_reg;
    assign status.hit  = s2_vld_reg & less;
    assign color       = col2_reg;

endmodule

/* design/circle_list_pixel_shader_unit.sv */
// top level of the circle list pixel shader
//
//  port group  dir  contents
//  s_*         in   circle table write or pixel request, tuser selects the operation
//  m_*         out  shaded pixel: address, color, coverage flag
//  cfg_*       in   register writes: width, height, reciprocal height, circle count
//
// a table write or an off-screen pixel is taken in idle and leaves the sequencer in idle
// an on-screen pixel passes through the mul, round, scan and done states; the scan
// reads entries in order over the single table read port until one hits or none are left
// reset is synchronous and clears the registers to their defaults; the table is not cleared
// a result waits in the output register while the next table write is taken;
// a finished pixel stalls until that register is free
`timescale 1ns / 1ps

module circle_list_pixel_shader_unit #(
    parameter int MAX_CIRCLES     = 256,
    parameter int COORD_FRAC_BITS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // entry_index, center_x, center_y, circle_radius, circle_color, pixel_x, pixel_y, pad
    input  logic [111:0]                         s_tdata,
    // operation
    input  logic                                 s_tuser,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pixel_address, pixel_color
    output logic [55:0]                          m_tdata,
    // covered
    output logic                                 m_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_wr_en,
    input  logic [clps_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [clps_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
    import clps_pkg::*;

`include "assert_macros.svh"

    localparam int AW    = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int CNT_W = $clog2(MAX_CIRCLES + 1);
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

    // input fields
    logic [7:0]  in_index;
    logic [11:0] in_px;
    logic [11:0] in_py;
    entry_t      in_entry;

    assign in_index        = s_tdata[7:0];
    assign in_entry.cx     = s_tdata[23:8];
    assign in_entry.cy     = s_tdata[39:24];
    assign in_entry.radius = s_tdata[54:40];
    assign in_entry.color  = s_tdata[86:55];
    assign in_px           = s_tdata[98:87];
    assign in_py           = s_tdata[110:99];

    // configuration registers
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [24:0] inv_reg;
    logic [8:0]  count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_SCREEN_WIDTH;
            height_reg <= RST_SCREEN_HEIGHT;
            inv_reg    <= RST_INV_HEIGHT;
            count_reg  <= RST_CIRCLE_COUNT;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_wr_data[12:0];
                REG_SCREEN_HEIGHT: height_reg <= cfg_wr_data[12:0];
                REG_INV_HEIGHT:    inv_reg    <= cfg_wr_data;
                REG_CIRCLE_COUNT:  count_reg  <= cfg_wr_data[8:0];
                default: ;
            endcase
        end
    end

    // entries scanned per pixel
    logic [CMP_W-1:0] n_eff;
    assign n_eff = (CMP_W'(count_reg) > CMP_W'(MAX_CIRCLES)) ? CMP_W'(MAX_CIRCLES)
                                                              : CMP_W'(count_reg);

    // control state
    state_t            state_reg, state_next;
    logic [11:0]       x_reg;
    logic [11:0]       y_reg;
    logic [23:0]       addr_reg;
    logic signed [15:0] u_reg;
    logic signed [15:0] v_reg;
    logic [CNT_W-1:0]  iss_reg;
    logic              rd_vld_reg;
    logic [31:0]       res_color_reg;
    logic              res_cov_reg;
    logic              m_tvalid_reg;
    logic [23:0]       m_addr_reg;
    logic [31:0]       m_color_reg;
    logic              m_cov_reg;

    logic              s_xfer;
    logic              on_screen;
    logic              tbl_wr_en;
    logic              rd_en;
    logic              coord_load;
    logic              flush;
    logic              scan_hit;
    logic              scan_miss;
    logic              out_load;
    logic signed [15:0] u_map;
    logic signed [15:0] v_map;
    entry_t            rd_entry;
    hit_status_t       hit_st;
    logic [31:0]       hit_color;

    assign s_xfer    = s_tvalid & s_tready;
    assign on_screen = ({1'b0, in_px} < width_reg) && ({1'b0, in_py} < height_reg);
    assign tbl_wr_en = s_xfer && (s_tuser == OP_WRITE) && (32'(in_index) < MAX_CIRCLES);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        rd_en      = 1'b0;
        coord_load = 1'b0;
        flush      = 1'b0;
        scan_hit   = 1'b0;
        scan_miss  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && (s_tuser == OP_SHADE) && on_screen) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                coord_load = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                flush      = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                rd_en = CMP_W'(iss_reg) < n_eff;
                if (hit_st.hit) begin
                    scan_hit   = 1'b1;
                    state_next = ST_DONE;
                end else if (!rd_en && !rd_vld_reg && !hit_st.busy) begin
                    scan_miss  = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // pixel request, address and mapped coordinates
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            x_reg <= in_px;
            y_reg <= in_py;
        end
        if (coord_load) begin
            addr_reg <= 24'(25'(y_reg) * 25'(width_reg) + 25'(x_reg));
        end
        if (state_reg == ST_ROUND) begin
            u_reg <= u_map;
            v_reg <= v_map;
        end
    end

    // scan issue counter and read valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
            if (state_reg == ST_ROUND) begin
                iss_reg <= '0;
            end else if (rd_en) begin
                iss_reg <= iss_reg + CNT_W'(1);
            end
        end
    end

    // scan result
    always_ff @(posedge aclk) begin
        if (scan_hit) begin
            res_color_reg <= hit_color;
            res_cov_reg   <= 1'b1;
        end else if (scan_miss) begin
            res_color_reg <= BLACK_OPAQUE;
            res_cov_reg   <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_addr_reg  <= addr_reg;
            m_color_reg <= res_color_reg;
            m_cov_reg   <= res_cov_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_color_reg, m_addr_reg};
    assign m_tuser  = m_cov_reg;

    // circle table
    clps_table #(
        .DEPTH (MAX_CIRCLES),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (AW'(in_index)),
        .wr_data (in_entry),
        .rd_en   (rd_en),
        .rd_addr (iss_reg[AW-1:0]),
        .rd_data (rd_entry)
    );

    // coordinate mapping
    clps_coord #(
        .FRAC (COORD_FRAC_BITS)
    ) u_coord_x (
        .aclk   (aclk),
        .load   (coord_load),
        .pix    (x_reg),
        .extent (width_reg),
        .inv    (inv_reg),
        .coord  (u_map)
    );

    clps_coord #(
        .FRAC (COORD_FRAC_BITS)
    ) u_coord_y (
        .aclk   (aclk),
        .load   (coord_load),
        .pix    (y_reg),
        .extent (height_reg),
        .inv    (inv_reg),
        .coord  (v_map)
    );

    // coverage test
    clps_hit u_hit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flush   (flush),
        .in_vld  (rd_vld_reg),
        .entry   (rd_entry),
        .u       (u_reg),
        .v       (v_reg),
        .status  (hit_st),
        .color   (hit_color)
    );

    // checks
    `ASSERT_CLK(a_wr_only_idle, tbl_wr_en |-> state_reg == ST_IDLE, "table write outside idle")
    `ASSERT_CLK(a_hit_ends_scan, (state_reg == ST_SCAN && hit_st.hit) |=> state_reg == ST_DONE,
                "hit did not end the scan")
    `ASSERT_CLK(a_out_from_done, $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE),
                "result loaded outside done")
    `ASSERT_ALWAYS(a_rst_idle, !aresetn |=> (state_reg == ST_IDLE && !m_tvalid_reg),
                   "reset did not clear control")

endmodule
